/* src/nrle_pkg.sv */
// Shared types and constants of the nibble run-length glyph decoder.
package nrle_pkg;

	localparam int unsigned WORD_W  = 32;
	localparam int unsigned INDEX_W = 7;
	localparam int unsigned NIB_W   = 4;
	localparam int unsigned RUN_W   = 3;

	// Byte sequencer states
	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_NIB  = 3'b010,
		ST_FIN  = 3'b100
	} seq_state_t;

	// Decode phase of the nibble stream
	typedef enum logic [2:0] {
		PH_HEADER  = 3'b001,
		PH_VALUE   = 3'b010,
		PH_LITERAL = 3'b100
	} phase_t;

	// Commands from the sequencer to the pixel unit
	typedef struct packed {
		logic             put;       // write one pixel
		logic [NIB_W-1:0] nib;       // pixel value
		logic             start;     // new byte: no word pending yet
		logic             block_end; // current byte is the last of the block
		logic             commit;    // byte finished, result taken into output
	} pix_ctrl_t;

	// One result word
	typedef struct packed {
		logic               truncated;
		logic               last_word;
		logic [INDEX_W-1:0] word_index;
		logic [WORD_W-1:0]  pixel_word;
	} word_t;

endpackage

/* src/nrle_pixel_unit.sv */
// Pixel packer: accumulates pixels into 32-bit words and holds the word of the current byte.
module nrle_pixel_unit
	import nrle_pkg::*;
#(
	parameter int unsigned GLYPH_NIBBLES = 576
) (
	input  logic      clk,
	input  logic      arst_n,
	input  pix_ctrl_t ctrl,
	output logic      full,
	output logic      res_valid,
	output word_t     res
);

	// Pixel count is wide enough for the glyph and for a full 7-bit word index
	localparam int unsigned NW_MIN = INDEX_W + 3;
	localparam int unsigned NW_W   = ($clog2(GLYPH_NIBBLES + 1) > NW_MIN) ?
		$clog2(GLYPH_NIBBLES + 1) : NW_MIN;

	logic [WORD_W-1:0]  acc_q;
	logic [NW_W-1:0]    nw_q;
	logic               have_q;
	logic [WORD_W-1:0]  word_q;
	logic [INDEX_W-1:0] index_q;
	logic               last_q;

	logic [WORD_W-1:0]  acc_put;
	logic [NW_W-1:0]    nw_inc;
	logic               wrap;
	logic               fin_put;
	logic               trunc;
	logic [NW_W-1:0]    nw_word;
	logic [NW_W-1:0]    nw_word_next;

	assign full = (nw_q >= NW_W'(GLYPH_NIBBLES));

	// Pixel insert at the current nibble slot
	assign acc_put = acc_q | ({{(WORD_W-NIB_W){1'b0}}, ctrl.nib} << {nw_q[2:0], 2'b00});
	assign nw_inc  = nw_q + NW_W'(1);
	assign fin_put = (nw_inc >= NW_W'(GLYPH_NIBBLES));
	assign wrap    = (nw_inc[2:0] == 3'd0) || fin_put;
	assign nw_word = nw_q >> 3;
	assign nw_word_next = nw_q >> 3;

	// Result of the byte: pending word, or the partial word when the block ends early
	assign trunc     = ctrl.block_end && !full;
	assign res_valid = have_q || trunc;
	always_comb begin
		res.truncated = trunc;
		res.last_word = last_q || trunc;
		if (have_q) begin
			res.pixel_word = word_q;
			res.word_index = index_q;
		end else begin
			res.pixel_word = acc_q;
			res.word_index = nw_word[INDEX_W-1:0];
		end
	end

	// Accumulator and pixel count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
			nw_q  <= '0;
		end else if (ctrl.commit && ctrl.block_end) begin
			acc_q <= '0;
			nw_q  <= '0;
		end else if (ctrl.put && !full) begin
			nw_q  <= nw_inc;
			acc_q <= wrap ? '0 : acc_put;
		end
	end

	// First completed word of the byte is held; later ones only raise last
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			have_q <= 1'b0;
			last_q <= 1'b0;
		end else if (ctrl.start) begin
			have_q <= 1'b0;
			last_q <= 1'b0;
		end else if (ctrl.put && !full && wrap) begin
			have_q <= 1'b1;
			if (!have_q) begin
				last_q <= fin_put;
			end else if (fin_put) begin
				last_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.put && !full && wrap && !have_q) begin
			word_q  <= acc_put;
			index_q <= nw_word_next[INDEX_W-1:0];
		end
	end

endmodule

/* src/nibble_rle_glyph_decoder.sv */
// Top level: byte sequencer, nibble decoder and output register of the glyph decoder.
//
// Usage:
//   Input stream s_*: one transfer per compressed byte (s_tdata[7:0]); the high
//   nibble is decoded first. A block is (GLYPH_NIBBLES+1)/2 bytes; after its last
//   byte all decode state restarts for the next glyph.
//   Output stream m_*: one transfer per finished 32-bit pixel word, first pixel
//   in bits 3:0, with its word index; m_tlast marks the last word of a glyph and
//   m_tuser flags a glyph whose block ended before it was complete.
//   Timing: after accept a byte passes ST_NIB (high nibble), ST_NIB (low nibble)
//   and ST_FIN; a repeat value stays in ST_NIB until its run is written, and a
//   new byte is taken only back in ST_IDLE. One pixel is written per cycle through
//   the shared packer. A result word shows on m_* the cycle after the byte ends.
//   Stall: the output register holds a word while m_tready is low; the next byte
//   is still taken and decoded, and it waits in its final step only if it too
//   produces a word before the held one is taken.
//   Reset: arst_n clears the sequencer, decode state and output valid at once.
module nibble_rle_glyph_decoder
	import nrle_pkg::*;
#(
	parameter int unsigned GLYPH_NIBBLES = 576
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] packed_byte
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,   // [31:0] pixel_word, [38:32] word_index, [39] zero
	output logic        m_tlast,   // last_word
	output logic        m_tuser    // truncated
);

	localparam int unsigned BLOCK_BYTES = (GLYPH_NIBBLES + 1) / 2;
	localparam int unsigned BY_W        = $clog2(BLOCK_BYTES);

	seq_state_t       state_q, state_d;
	phase_t           phase_q, phase_d;
	logic [RUN_W-1:0] run_q, run_d;
	logic [7:0]       byte_q;
	logic             nib_sel_q;
	logic [BY_W-1:0]  bytes_q;

	logic [NIB_W-1:0] nib;
	logic             advance;
	logic             put;
	logic             full;
	logic             res_valid;
	word_t            res;
	pix_ctrl_t        ctrl;
	logic             block_end;
	logic             fin_go;
	logic             load_out;

	logic             m_tvalid_q;
	word_t            out_q;

	assign s_tready  = (state_q == ST_IDLE);
	assign nib       = nib_sel_q ? byte_q[3:0] : byte_q[7:4];
	assign block_end = (bytes_q == BY_W'(BLOCK_BYTES - 1));
	assign fin_go    = (state_q == ST_FIN) && (!res_valid || !m_tvalid_q || m_tready);
	assign load_out  = fin_go && res_valid;

	// Nibble decode: one header, literal pixel or repeat pixel per cycle while in ST_NIB
	always_comb begin
		phase_d = phase_q;
		run_d   = run_q;
		advance = 1'b0;
		put     = 1'b0;
		if (state_q == ST_NIB) begin
			if (full) begin
				advance = 1'b1;
			end else begin
				case (phase_q)
					PH_HEADER: begin
						run_d   = nib[RUN_W-1:0];
						advance = 1'b1;
						if (nib[3]) begin
							phase_d = PH_VALUE;
						end else if (nib[RUN_W-1:0] != '0) begin
							phase_d = PH_LITERAL;
						end else begin
							phase_d = PH_HEADER;
						end
					end
					PH_LITERAL: begin
						put     = 1'b1;
						run_d   = run_q - RUN_W'(1);
						advance = 1'b1;
						if (run_q == RUN_W'(1)) begin
							phase_d = PH_HEADER;
						end
					end
					PH_VALUE: begin
						if (run_q == '0) begin
							phase_d = PH_HEADER;
							advance = 1'b1;
						end else begin
							put   = 1'b1;
							run_d = run_q - RUN_W'(1);
							if (run_q == RUN_W'(1)) begin
								phase_d = PH_HEADER;
								advance = 1'b1;
							end
						end
					end
					default: begin
						phase_d = PH_HEADER;
						advance = 1'b1;
					end
				endcase
			end
		end
	end

	// Sequencer next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					state_d = ST_NIB;
				end
			end
			ST_NIB: begin
				if (advance && nib_sel_q) begin
					state_d = ST_FIN;
				end
			end
			ST_FIN: begin
				if (fin_go) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		ctrl.put       = put;
		ctrl.nib       = nib;
		ctrl.start     = (state_q == ST_IDLE) && s_tvalid;
		ctrl.block_end = block_end;
		ctrl.commit    = fin_go;
	end

	nrle_pixel_unit #(
		.GLYPH_NIBBLES(GLYPH_NIBBLES)
	) u_pixel (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctrl     (ctrl),
		.full     (full),
		.res_valid(res_valid),
		.res      (res)
	);

	// Control and decode state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			phase_q   <= PH_HEADER;
			run_q     <= '0;
			nib_sel_q <= 1'b0;
			bytes_q   <= '0;
		end else begin
			state_q <= state_d;
			if (fin_go && block_end) begin
				phase_q <= PH_HEADER;
				run_q   <= '0;
				bytes_q <= '0;
			end else begin
				phase_q <= phase_d;
				run_q   <= run_d;
				if (fin_go) begin
					bytes_q <= bytes_q + BY_W'(1);
				end
			end
			if (ctrl.start) begin
				nib_sel_q <= 1'b0;
			end else if (state_q == ST_NIB && advance) begin
				nib_sel_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.start) begin
			byte_q <= s_tdata;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (load_out) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_q <= res;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {1'b0, out_q.word_index, out_q.pixel_word};
	assign m_tlast  = out_q.last_word;
	assign m_tuser  = out_q.truncated;

endmodule

/* tb/sv/nibble_rle_glyph_decoder_test.sv */
// Self-checking stream testbench for the nibble run-length glyph decoder.
module nibble_rle_glyph_decoder_test;
	import nrle_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned GLYPH_NIBBLES = 576;
	localparam int unsigned BLOCK_BYTES   = (GLYPH_NIBBLES + 1) / 2;
	localparam int unsigned ITEM_TARGET   = 550;
	localparam int unsigned DIR_ROWS      = 21;

	// Shape of the nibble stream used for one block
	typedef enum int {
		BLK_SPARSE,
		BLK_DENSE,
		BLK_MIXED
	} blk_kind_t;

	// Directed row: byte, whether the result is typed in, and that result
	typedef struct packed {
		logic [7:0] data;
		logic       typed;
		logic       has_word;
		word_t      w;
	} dir_row_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [7:0]  s_tdata;   // [7:0] packed_byte
	logic        m_tvalid;
	logic        m_tready;
	logic [39:0] m_tdata;   // [31:0] pixel_word, [38:32] word_index, [39] zero
	logic        m_tlast;   // last_word
	logic        m_tuser;   // truncated

	// Decoder state as seen by the predictor
	int unsigned blk_bytes;
	int unsigned pix_count;
	phase_t      phase;
	logic [2:0]  run_left;
	logic [31:0] acc;
	bit          word_ready;
	word_t       word_out;

	word_t       pending_words[$];
	int unsigned mismatches;
	int unsigned words_seen;
	int unsigned send_calm;
	dir_row_t    dir_table [DIR_ROWS];

	nibble_rle_glyph_decoder #(
		.GLYPH_NIBBLES(GLYPH_NIBBLES)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tlast(m_tlast),
		.m_tuser(m_tuser)
	);

	always #4 clk = ~clk;

	// Start a new glyph
	function automatic void restart_glyph();
		blk_bytes = 0;
		pix_count = 0;
		phase = PH_HEADER;
		run_left = '0;
		acc = '0;
	endfunction

	// Pack one pixel; a filled word is kept only if none is pending for this byte
	function automatic void emit_pixel(logic [3:0] nib);
		if (pix_count >= GLYPH_NIBBLES)
			return;
		acc = acc | ({28'd0, nib} << (4 * (pix_count % 8)));
		pix_count++;
		if (pix_count % 8 == 0 || pix_count >= GLYPH_NIBBLES) begin
			if (!word_ready) begin
				word_ready = 1'b1;
				word_out.pixel_word = acc;
				word_out.word_index = 7'((pix_count - 1) >> 3);
				word_out.last_word = (pix_count >= GLYPH_NIBBLES);
			end else if (pix_count >= GLYPH_NIBBLES) begin
				word_out.last_word = 1'b1;
			end
			acc = '0;
		end
	endfunction

	// Run one nibble through the header / value / literal sequence
	function automatic void decode_nibble(logic [3:0] nib);
		if (pix_count >= GLYPH_NIBBLES)
			return;
		case (phase)
			PH_VALUE: begin
				for (int k = 0; k < run_left; k++)
					emit_pixel(nib);
				run_left = '0;
				phase = PH_HEADER;
			end
			PH_LITERAL: begin
				emit_pixel(nib);
				run_left = run_left - 3'd1;
				if (run_left == 3'd0)
					phase = PH_HEADER;
			end
			default: begin
				run_left = nib[2:0];
				if (nib[3])
					phase = PH_VALUE;
				else if (run_left != 3'd0)
					phase = PH_LITERAL;
				else
					phase = PH_HEADER;
			end
		endcase
	endfunction

	// Expected word for one byte, if any; handles the end of the block
	function automatic bit decode_byte(input logic [7:0] b, output word_t w);
		bit trunc;
		trunc = 1'b0;
		word_ready = 1'b0;
		word_out = '0;
		decode_nibble(b[7:4]);
		decode_nibble(b[3:0]);
		blk_bytes++;
		if (blk_bytes >= BLOCK_BYTES) begin
			if (pix_count < GLYPH_NIBBLES) begin
				trunc = 1'b1;
				if (!word_ready) begin
					word_ready = 1'b1;
					word_out.pixel_word = acc;
					word_out.word_index = 7'(pix_count >> 3);
				end
				word_out.last_word = 1'b1;
			end
			restart_glyph();
		end
		word_out.truncated = trunc;
		w = word_out;
		return word_ready;
	endfunction

	// Idle length: mostly short, a few long
	function automatic int unsigned idle_len();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 50)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 96)
			return $urandom_range(4, 12);
		return $urandom_range(20, 40);
	endfunction

	// Offer one byte, wait for the transfer, then record what it should produce
	task automatic send_byte(input logic [7:0] b, input bit typed, input bit typed_has,
		input word_t typed_w);
		int unsigned gap;
		bit got;
		word_t w;
		if (send_calm > 0) begin
			send_calm--;
			gap = 0;
		end else if ($urandom_range(0, 99) < 4) begin
			send_calm = $urandom_range(20, 60);
			gap = 0;
		end else begin
			gap = idle_len();
		end
		@(negedge clk);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= b;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		got = decode_byte(b, w);
		if (typed) begin
			got = typed_has;
			w = typed_w;
		end
		if (got)
			pending_words.push_back(w);
	endtask

	// Output side: compare each word transfer with the oldest expectation
	always @(posedge clk) begin
		word_t w;
		if (arst_n && m_tvalid && m_tready) begin
			words_seen++;
			if (pending_words.size() == 0) begin
				$error("unexpected word: data %h last %b truncated %b",
					m_tdata, m_tlast, m_tuser);
				mismatches++;
			end else begin
				w = pending_words.pop_front();
				if (m_tdata[31:0] !== w.pixel_word) begin
					$error("pixel_word: expected %h, got %h", w.pixel_word, m_tdata[31:0]);
					mismatches++;
				end
				if (m_tdata[38:32] !== w.word_index) begin
					$error("word_index: expected %0d, got %0d", w.word_index, m_tdata[38:32]);
					mismatches++;
				end
				if (m_tdata[39] !== 1'b0) begin
					$error("tdata pad bit: expected 0, got %b", m_tdata[39]);
					mismatches++;
				end
				if (m_tlast !== w.last_word) begin
					$error("last_word: expected %b, got %b", w.last_word, m_tlast);
					mismatches++;
				end
				if (m_tuser !== w.truncated) begin
					$error("truncated: expected %b, got %b", w.truncated, m_tuser);
					mismatches++;
				end
			end
		end
	end

	// Output side: random stalls, calm stretches, and one long hold-off to back up the input
	initial begin
		int unsigned calm;
		int unsigned stall;
		int unsigned hold;
		bit held;
		calm = 0;
		stall = 0;
		hold = 0;
		held = 1'b0;
		m_tready <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold > 0) begin
				hold--;
				m_tready <= 1'b0;
			end else if (!held && words_seen >= 40) begin
				held = 1'b1;
				hold = 299;
				m_tready <= 1'b0;
			end else if (stall > 0) begin
				stall--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
				if (calm > 0)
					calm--;
				else if ($urandom_range(0, 99) < 4)
					calm = $urandom_range(30, 100);
				else
					stall = idle_len();
			end
		end
	end

	// Stimulus
	initial begin
		blk_kind_t kind;
		logic [3:0] nib_plan[$];
		logic [3:0] hi;
		logic [3:0] lo;
		logic [7:0] b;
		int unsigned counted;
		int unsigned r;
		int unsigned cnt;
		bit rep;

		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		mismatches = 0;
		words_seen = 0;
		send_calm = 0;
		counted = 0;
		restart_glyph();

		// Directed rows: extremes, repeat and literal runs, zero counts.
		// Fields of w: truncated, last_word, word_index, pixel_word.
		dir_table = '{
			'{8'hFF, 1'b1, 1'b0, '0},                               // repeat 7 of F
			'{8'h1A, 1'b1, 1'b1, '{1'b0, 1'b0, 7'd0, 32'hAFFF_FFFF}}, // literal A fills word 0
			'{8'h80, 1'b1, 1'b0, '0},                               // repeat count zero
			'{8'h00, 1'b1, 1'b0, '0},                               // two zero-count literal headers
			'{8'h7F, 1'b0, 1'b0, '0},
			'{8'h01, 1'b0, 1'b0, '0},
			'{8'h23, 1'b0, 1'b0, '0},
			'{8'h45, 1'b0, 1'b0, '0},
			'{8'h8F, 1'b0, 1'b0, '0},
			'{8'hF0, 1'b0, 1'b0, '0},
			'{8'h0F, 1'b0, 1'b0, '0},
			'{8'h59, 1'b0, 1'b0, '0},
			'{8'hC8, 1'b0, 1'b0, '0},
			'{8'h3E, 1'b0, 1'b0, '0},
			'{8'h77, 1'b0, 1'b0, '0},
			'{8'h12, 1'b0, 1'b0, '0},
			'{8'h34, 1'b0, 1'b0, '0},
			'{8'h56, 1'b0, 1'b0, '0},
			'{8'h7A, 1'b0, 1'b0, '0},
			'{8'hB0, 1'b0, 1'b0, '0},
			'{8'h08, 1'b0, 1'b0, '0}
		};

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		for (int i = 0; i < DIR_ROWS; i++) begin
			send_byte(dir_table[i].data, dir_table[i].typed, dir_table[i].has_word,
				dir_table[i].w);
			counted++;
		end

		// Random part: the directed block finishes literal-heavy, so it ends truncated
		kind = BLK_SPARSE;
		while (counted < ITEM_TARGET) begin
			if (blk_bytes == 0) begin
				r = $urandom_range(0, 99);
				kind = (r < 50) ? BLK_DENSE : (r < 85) ? BLK_MIXED : BLK_SPARSE;
				nib_plan.delete();
			end
			if (pix_count >= GLYPH_NIBBLES) begin
				// glyph full: rest of the block is ignored
				b = 8'($urandom_range(0, 255));
			end else if (blk_bytes == BLOCK_BYTES - 1 && phase == PH_HEADER &&
				pix_count % 8 >= 2 && $urandom_range(0, 1) == 1) begin
				// last byte completes a word and spills into the next one
				lo = 4'($urandom_range(0, 15));
				b = {4'hF, lo};
			end else begin
				while (nib_plan.size() < 2) begin
					r = $urandom_range(0, 99);
					if (r < 5) begin
						// stray nibble breaks the run structure
						nib_plan.push_back(4'($urandom_range(0, 15)));
					end else begin
						case (kind)
							BLK_DENSE: begin
								rep = (r < 88);
								cnt = rep ? $urandom_range(4, 7) : $urandom_range(1, 7);
							end
							BLK_MIXED: begin
								rep = 1'($urandom_range(0, 1));
								cnt = $urandom_range(0, 7);
							end
							default: begin
								rep = (r < 15);
								cnt = rep ? $urandom_range(0, 2) : $urandom_range(0, 7);
							end
						endcase
						nib_plan.push_back({rep, cnt[2:0]});
						if (rep)
							nib_plan.push_back(4'($urandom_range(0, 15)));
						else
							repeat (cnt) nib_plan.push_back(4'($urandom_range(0, 15)));
					end
				end
				hi = nib_plan.pop_front();
				lo = nib_plan.pop_front();
				b = {hi, lo};
			end
			send_byte(b, 1'b0, 1'b0, '0);
			counted++;
		end

		@(negedge clk);
		s_tvalid <= 1'b0;

		// Drain, then give the block time to show any stray word
		while (pending_words.size() != 0)
			@(posedge clk);
		repeat (100) @(posedge clk);

		if (mismatches == 0 && pending_words.size() == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

	// Watchdog
	initial begin
		#8_000_000;
		$display("Regression FAIL");
		$finish;
	end

endmodule

/* sim.f */
src/nrle_pkg.sv
src/nrle_pixel_unit.sv
src/nibble_rle_glyph_decoder.sv
tb/sv/nibble_rle_glyph_decoder_test.sv
